[design/pfm_pkg.sv]
// Package for the policy feedback monitor: payload structs, status and
// command codes, configuration register indexes and reset values.
// No dependencies; used by policy_feedback_monitor.
`timescale 1ns / 1ps

package pfm_pkg;

  // Widths of the fields and registers.
  localparam int unsigned RttW   = 24;
  localparam int unsigned CountW = 16;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 48;

  // Opcodes of an input item.
  typedef enum logic {
    OP_DISPATCH = 1'b0,
    OP_EVALUATE = 1'b1
  } pfm_opcode_e;

  // Tuning commands.
  typedef enum logic [2:0] {
    CMD_NONE        = 3'd0,
    CMD_BG_RESTRICT = 3'd1,
    CMD_IRQ_REPIN   = 3'd2,
    CMD_STICKY      = 3'd3,
    CMD_ROLLBACK    = 3'd4
  } pfm_command_e;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_CLEARED      = 4'd0,
    ST_FAILED       = 4'd1,
    ST_UNTRACKABLE  = 4'd2,
    ST_COOLDOWN     = 4'd3,
    ST_BUSY         = 4'd4,
    ST_ARMED        = 4'd5,
    ST_IDLE         = 4'd6,
    ST_PASSED       = 4'd7,
    ST_PENDING      = 4'd8,
    ST_ROLLBACK     = 4'd9,
    ST_INCONCLUSIVE = 4'd10
  } pfm_status_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_WINDOW_CYCLES       = 4'd0,
    CFG_REGRESSION_REQUIRED = 4'd1,
    CFG_MIN_RTT_IMPROVEMENT = 4'd2,
    CFG_ACCEPTABLE_RTT      = 4'd3,
    CFG_RTT_REGRESSION_TOL  = 4'd4,
    CFG_COUNT_THRESHOLDS    = 4'd5,
    CFG_REARM_COOLDOWN      = 4'd6,
    CFG_ROLLBACK_ENABLE     = 4'd7
  } pfm_cfg_idx_e;

  // Reset values of the window and required-count registers, which do not reset to zero.
  localparam logic [CountW-1:0] WindowReset   = 16'd3;
  localparam logic [CountW-1:0] RequiredReset = 16'd2;

  // Largest value of a saturating counter.
  localparam logic [CountW-1:0] CountMax = '1;

  // One input item.
  typedef struct packed {
    logic              opcode;
    logic [2:0]        command;
    logic              dispatch_ok;
    logic [RttW-1:0]   rtt_jitter_us;
    logic [CountW-1:0] dpc_spikes;
    logic [CountW-1:0] migrations;
    logic              affinity_supported;
    logic [TimeW-1:0]  now_ms;
  } pfm_in_t;

  // One result item.
  typedef struct packed {
    logic [3:0]        status;
    logic              rollback_request;
    logic              tracking_active;
    logic [CountW-1:0] observed_count;
    logic [CountW-1:0] regression_count;
  } pfm_out_t;

endpackage

[design/policy_feedback_monitor.sv]
// Policy feedback monitor: tracks one applied tuning action and judges it.
// Depends on pfm_pkg for payload structs, codes and register indexes.
//
//   Channel | Signals                              | Direction
//   --------+--------------------------------------+----------
//   input   | in_valid_i, in_ready_o, in_data_i    | in
//   result  | out_valid_o, out_ready_i, out_data_o | out
//   config  | cfg_valid_i, cfg_ready_o, cfg_index_i, cfg_data_i | in
//
// Every input transfer yields one result in the next cycle; a new item is taken in
// every cycle unless a held result blocks the input, so the sustained rate is one item per clock.
// The judgement is a single pass of compares and counter updates between the
// tracking state and the result register.
// A held result blocks the input only while the result register is full and
// not being taken in the same cycle.
// Reset (rst_ni low, asynchronous) clears the tracking state and loads the
// register defaults. Configuration writes are always taken.
`timescale 1ns / 1ps

module policy_feedback_monitor (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  pfm_pkg::pfm_in_t                    in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output pfm_pkg::pfm_out_t                   out_data_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pfm_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [pfm_pkg::CfgDataW-1:0]        cfg_data_i
);

  // Configuration registers.
  logic [pfm_pkg::CountW-1:0]   window_q;
  logic [pfm_pkg::CountW-1:0]   required_q;
  logic [pfm_pkg::RttW-1:0]     min_rtt_q;
  logic [pfm_pkg::RttW-1:0]     acc_rtt_q;
  logic [pfm_pkg::RttW-1:0]     rtt_tol_q;
  logic [pfm_pkg::CfgDataW-1:0] counts_q;
  logic [pfm_pkg::TimeW-1:0]    cooldown_q;
  logic                         rb_en_q;

  // Tracking state.
  logic                         active_q, active_d;
  logic [1:0]                   tracked_q, tracked_d;
  logic [pfm_pkg::RttW-1:0]     base_rtt_q, base_rtt_d;
  logic [pfm_pkg::CountW-1:0]   base_dpc_q, base_dpc_d;
  logic [pfm_pkg::CountW-1:0]   base_mig_q, base_mig_d;
  logic [pfm_pkg::CountW-1:0]   cycles_q, cycles_d;
  logic [pfm_pkg::CountW-1:0]   regress_q, regress_d;
  logic                         latched_q, latched_d;
  logic [2:0]                   done_cmd_q, done_cmd_d;
  logic [pfm_pkg::TimeW-1:0]    done_time_q, done_time_d;
  logic                         done_valid_q, done_valid_d;

  // Result register.
  logic                         out_valid_q;
  pfm_pkg::pfm_out_t            out_data_q, out_data_d;

  logic                         in_fire;

  // Working values of the evaluation.
  logic [pfm_pkg::CountW-1:0]   win_eff;
  logic [pfm_pkg::CountW-1:0]   req_nz;
  logic [pfm_pkg::CountW-1:0]   req_eff;
  logic [pfm_pkg::CountW-1:0]   cycles_inc;
  logic [pfm_pkg::RttW-1:0]     base_sel;
  logic [pfm_pkg::RttW-1:0]     cur_sel;
  logic [pfm_pkg::RttW-1:0]     imp_sel;
  logic [pfm_pkg::RttW-1:0]     tol_sel;
  logic [pfm_pkg::RttW:0]       cur_plus_imp;
  logic [pfm_pkg::RttW:0]       base_plus_tol;
  logic                         improved;
  logic                         regressed;
  logic                         trackable;
  logic                         in_cooldown;
  logic [pfm_pkg::TimeW-1:0]    elapsed;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign cfg_ready_o = 1'b1;

  // Configuration register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= pfm_pkg::WindowReset;
      required_q <= pfm_pkg::RequiredReset;
      min_rtt_q  <= '0;
      acc_rtt_q  <= '0;
      rtt_tol_q  <= '0;
      counts_q   <= '0;
      cooldown_q <= '0;
      rb_en_q    <= 1'b1;
    end else if (cfg_valid_i) begin
      case (pfm_pkg::pfm_cfg_idx_e'(cfg_index_i))
        pfm_pkg::CFG_WINDOW_CYCLES:       window_q   <= cfg_data_i[pfm_pkg::CountW-1:0];
        pfm_pkg::CFG_REGRESSION_REQUIRED: required_q <= cfg_data_i[pfm_pkg::CountW-1:0];
        pfm_pkg::CFG_MIN_RTT_IMPROVEMENT: min_rtt_q  <= cfg_data_i[pfm_pkg::RttW-1:0];
        pfm_pkg::CFG_ACCEPTABLE_RTT:      acc_rtt_q  <= cfg_data_i[pfm_pkg::RttW-1:0];
        pfm_pkg::CFG_RTT_REGRESSION_TOL:  rtt_tol_q  <= cfg_data_i[pfm_pkg::RttW-1:0];
        pfm_pkg::CFG_COUNT_THRESHOLDS:    counts_q   <= cfg_data_i;
        pfm_pkg::CFG_REARM_COOLDOWN:      cooldown_q <= cfg_data_i[pfm_pkg::TimeW-1:0];
        pfm_pkg::CFG_ROLLBACK_ENABLE:     rb_en_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Effective window and required count, and the metric of the tracked command.
  always_comb begin
    win_eff    = (window_q == '0) ? pfm_pkg::CountW'(1) : window_q;
    req_nz     = (required_q == '0) ? pfm_pkg::CountW'(1) : required_q;
    req_eff    = (req_nz > win_eff) ? win_eff : req_nz;
    cycles_inc = (cycles_q == pfm_pkg::CountMax) ? cycles_q : cycles_q + 1'b1;

    tol_sel = pfm_pkg::RttW'(counts_q[47:32]);
    case (tracked_q)
      2'd1: begin
        base_sel = base_rtt_q;
        cur_sel  = in_data_i.rtt_jitter_us;
        imp_sel  = min_rtt_q;
        tol_sel  = rtt_tol_q;
      end
      2'd2: begin
        base_sel = pfm_pkg::RttW'(base_dpc_q);
        cur_sel  = pfm_pkg::RttW'(in_data_i.dpc_spikes);
        imp_sel  = pfm_pkg::RttW'(counts_q[15:0]);
      end
      default: begin
        base_sel = pfm_pkg::RttW'(base_mig_q);
        cur_sel  = pfm_pkg::RttW'(in_data_i.migrations);
        imp_sel  = pfm_pkg::RttW'(counts_q[31:16]);
      end
    endcase

    // base - cur >= imp and cur - base > tol, rearranged to stay unsigned.
    cur_plus_imp  = {1'b0, cur_sel} + {1'b0, imp_sel};
    base_plus_tol = {1'b0, base_sel} + {1'b0, tol_sel};
    improved  = ({1'b0, base_sel} >= cur_plus_imp) && (tracked_q != 2'd0) &&
                ((tracked_q != 2'd1) || (in_data_i.rtt_jitter_us <= acc_rtt_q));
    regressed = ({1'b0, cur_sel} > base_plus_tol) && (tracked_q != 2'd0);
  end

  // Dispatch qualification.
  always_comb begin
    case (pfm_pkg::pfm_command_e'(in_data_i.command))
      pfm_pkg::CMD_BG_RESTRICT: trackable = (in_data_i.rtt_jitter_us != '0);
      pfm_pkg::CMD_IRQ_REPIN:   trackable = in_data_i.affinity_supported &&
                                            (in_data_i.dpc_spikes != '0);
      pfm_pkg::CMD_STICKY:      trackable = (in_data_i.migrations != '0);
      default:                  trackable = 1'b0;
    endcase
    elapsed     = in_data_i.now_ms - done_time_q;
    in_cooldown = done_valid_q && (done_cmd_q == in_data_i.command) &&
                  (elapsed < cooldown_q);
  end

  // Next tracking state and the result of the item.
  always_comb begin
    active_d     = active_q;
    tracked_d    = tracked_q;
    base_rtt_d   = base_rtt_q;
    base_dpc_d   = base_dpc_q;
    base_mig_d   = base_mig_q;
    cycles_d     = cycles_q;
    regress_d    = regress_q;
    latched_d    = latched_q;
    done_cmd_d   = done_cmd_q;
    done_time_d  = done_time_q;
    done_valid_d = done_valid_q;
    out_data_d.status           = pfm_pkg::ST_IDLE;
    out_data_d.rollback_request = 1'b0;

    if (in_data_i.opcode == pfm_pkg::OP_DISPATCH) begin
      if (in_data_i.command == pfm_pkg::CMD_ROLLBACK) begin
        active_d     = 1'b0;
        tracked_d    = '0;
        cycles_d     = '0;
        regress_d    = '0;
        done_cmd_d   = pfm_pkg::CMD_NONE;
        done_time_d  = '0;
        done_valid_d = 1'b0;
        latched_d    = 1'b1;
        out_data_d.status = pfm_pkg::ST_CLEARED;
      end else if (!in_data_i.dispatch_ok) begin
        out_data_d.status = pfm_pkg::ST_FAILED;
      end else if (!trackable) begin
        out_data_d.status = pfm_pkg::ST_UNTRACKABLE;
      end else if (in_cooldown) begin
        out_data_d.status = pfm_pkg::ST_COOLDOWN;
      end else if (active_q) begin
        out_data_d.status = pfm_pkg::ST_BUSY;
      end else begin
        active_d   = 1'b1;
        tracked_d  = in_data_i.command[1:0];
        base_rtt_d = in_data_i.rtt_jitter_us;
        base_dpc_d = in_data_i.dpc_spikes;
        base_mig_d = in_data_i.migrations;
        cycles_d   = '0;
        regress_d  = '0;
        latched_d  = 1'b0;
        out_data_d.status = pfm_pkg::ST_ARMED;
      end
    end else if (active_q && !latched_q) begin
      cycles_d = cycles_inc;
      if (!improved) begin
        if (regressed) begin
          regress_d = (regress_q == pfm_pkg::CountMax) ? regress_q : regress_q + 1'b1;
        end else begin
          regress_d = '0;
        end
      end
      if (improved) begin
        out_data_d.status = pfm_pkg::ST_PASSED;
      end else if (cycles_inc < win_eff) begin
        out_data_d.status = pfm_pkg::ST_PENDING;
      end else if (rb_en_q && (regress_d >= req_eff)) begin
        out_data_d.status           = pfm_pkg::ST_ROLLBACK;
        out_data_d.rollback_request = 1'b1;
        latched_d                   = 1'b1;
      end else begin
        out_data_d.status = pfm_pkg::ST_INCONCLUSIVE;
      end
      // A closed window records the command and time for the cooldown.
      if (out_data_d.status != pfm_pkg::ST_PENDING) begin
        done_cmd_d   = {1'b0, tracked_q};
        done_time_d  = in_data_i.now_ms;
        done_valid_d = 1'b1;
        active_d     = 1'b0;
      end
    end

    out_data_d.tracking_active  = active_d;
    out_data_d.observed_count   = cycles_d;
    out_data_d.regression_count = regress_d;
  end

  // Tracking state registers, updated on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q     <= 1'b0;
      tracked_q    <= '0;
      base_rtt_q   <= '0;
      base_dpc_q   <= '0;
      base_mig_q   <= '0;
      cycles_q     <= '0;
      regress_q    <= '0;
      latched_q    <= 1'b0;
      done_cmd_q   <= pfm_pkg::CMD_NONE;
      done_time_q  <= '0;
      done_valid_q <= 1'b0;
    end else if (in_fire) begin
      active_q     <= active_d;
      tracked_q    <= tracked_d;
      base_rtt_q   <= base_rtt_d;
      base_dpc_q   <= base_dpc_d;
      base_mig_q   <= base_mig_d;
      cycles_q     <= cycles_d;
      regress_q    <= regress_d;
      latched_q    <= latched_d;
      done_cmd_q   <= done_cmd_d;
      done_time_q  <= done_time_d;
      done_valid_q <= done_valid_d;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload, loaded with each input transfer.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

`ifndef SYNTHESIS
  // A rollback request only travels with the rollback status.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.rollback_request |->
      out_data_q.status == pfm_pkg::ST_ROLLBACK)
    else $error("rollback request without rollback status");

  // An armed window always tracks a real command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> tracked_q != 2'd0)
    else $error("active window without a tracked command");

  // The rollback latch and an open window never coexist.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(active_q && latched_q))
    else $error("rollback latched while a window is active");

  // Every input transfer leaves a result waiting in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("input transfer produced no result");

  // The armed status reports an active window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q.status == pfm_pkg::ST_ARMED |->
      out_data_q.tracking_active)
    else $error("armed result without active tracking");
`endif

endmodule
